// ===== rtl/core/tst_pkg.sv =====
// Shared types, codes and the character class table of the term syntax tokenizer.
`timescale 1ns / 1ps

package tst_pkg;

    // Default length limit for one token
    localparam int TST_MAX_TOKEN_LEN = 256;

    // Widths of the word fields
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CLASS_W = 3;
    localparam int STATE_W = 4;
    localparam int USER_W  = 7;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [STATE_W-1:0] lex_state_t;

    // Character classes
    localparam class_t C_WS = 3'd0;
    localparam class_t C_UP = 3'd1;
    localparam class_t C_LO = 3'd2;
    localparam class_t C_DG = 3'd3;
    localparam class_t C_SQ = 3'd4;
    localparam class_t C_DQ = 3'd5;
    localparam class_t C_SY = 3'd6;
    localparam class_t C_SO = 3'd7;

    // Lexer states
    localparam lex_state_t S_IDLE = 4'd0;
    localparam lex_state_t S_DQB  = 4'd1;
    localparam lex_state_t S_DQC  = 4'd2;
    localparam lex_state_t S_SQB  = 4'd3;
    localparam lex_state_t S_SQC  = 4'd4;
    localparam lex_state_t S_SYM  = 4'd5;
    localparam lex_state_t S_INT  = 4'd6;
    localparam lex_state_t S_VAR  = 4'd7;
    localparam lex_state_t S_IDN  = 4'd8;

    // Token kinds
    localparam kind_t K_STRING = 3'd0;
    localparam kind_t K_QCONST = 3'd1;
    localparam kind_t K_SOLO   = 3'd2;
    localparam kind_t K_SYMBOL = 3'd3;
    localparam kind_t K_INT    = 3'd4;
    localparam kind_t K_VAR    = 3'd5;
    localparam kind_t K_IDENT  = 3'd6;

    // Quote characters
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_SQUOTE = 8'h27;

    // Result flags travel in the user field
    typedef struct packed {
        logic  too_long;
        logic  bad_char;
        logic  open_at_end;
        logic  first;
        kind_t kind;
    } res_user_t;

    // Class of a 7-bit character code (the 128-entry table)
    function automatic class_t char_class(input logic [6:0] c);
        class_t cls;
        cls = C_SY;
        if (c <= 7'd32 || c == 7'd127) begin
            cls = C_WS;
        end else if (c >= 7'd48 && c <= 7'd57) begin
            cls = C_DG;
        end else if ((c >= 7'd65 && c <= 7'd90) || c == 7'd95) begin
            cls = C_UP;
        end else if ((c >= 7'd97 && c <= 7'd122) || c == 7'd36) begin
            cls = C_LO;
        end else if (c == 7'd34) begin
            cls = C_DQ;
        end else if (c == 7'd39) begin
            cls = C_SQ;
        end else if (c == 7'd33 || c == 7'd37 || c == 7'd40 || c == 7'd41 ||
                     c == 7'd44 || c == 7'd59 || c == 7'd91 || c == 7'd93 ||
                     c == 7'd123 || c == 7'd124 || c == 7'd125) begin
            cls = C_SO;
        end
        return cls;
    endfunction

endpackage

// ===== rtl/core/term_syntax_tokenizer.sv =====
// Top level of the term syntax tokenizer: byte-serial lexer with input and result registers.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata = ch, s_tlast = end_of_input
//  m_       | out | m_tvalid/m_tready  | m_tdata = char_out, m_tuser = flags, m_tlast = at_end
//
// One word is taken per cycle for as long as results are taken. A word is held in the input
// register; the class lookup and the state update run between it and the result register,
// which is loaded from that word when it advances out of the input register.
// Reset puts the lexer in the idle state with a zero token length and both registers empty.
// When the result register is held, the input register keeps its word and s_tready drops.
// Whitespace words give no result, but they also wait while the result register is held.
`timescale 1ns / 1ps

module term_syntax_tokenizer
    import tst_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = TST_MAX_TOKEN_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] ch
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] char_out
    output logic [USER_W-1:0] m_tuser,   // [2:0] kind, [3] first, [4] open_at_end,
                                         // [5] bad_char, [6] too_long
    output logic              m_tlast
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    typedef logic [LEN_W-1:0] len_t;

    // Input register
    logic      in_valid_reg;
    char_t     in_ch_reg;
    logic      in_last_reg;

    // Lexer state
    lex_state_t lex_state_reg, lex_state_next;
    len_t       len_reg, len_next;

    // Result register
    logic      out_valid_reg;
    char_t     out_ch_reg;
    res_user_t out_user_reg;
    logic      out_last_reg;

    // Combinational result
    logic      emit;
    char_t     res_ch;
    res_user_t res_user;
    logic      res_last;

    logic      advance;
    logic      cont;
    kind_t     cont_kind;
    lex_state_t cont_state;
    class_t    cls;
    len_t      len_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Class lookup; codes of 128 and above are handled apart
    assign cls     = char_class(in_ch_reg[6:0]);
    assign len_inc = (len_reg <= LEN_MAX) ? len_reg + LEN_ONE : len_reg;

    // Does the word continue the open token?
    always_comb
    begin
        cont       = 1'b0;
        cont_kind  = K_STRING;
        cont_state = lex_state_reg;
        case (lex_state_reg)
            S_DQB:
            begin
                cont       = 1'b1;
                cont_kind  = K_STRING;
                cont_state = (in_ch_reg == CH_DQUOTE) ? S_DQC : S_DQB;
            end
            S_DQC:
            begin
                cont       = (in_ch_reg == CH_DQUOTE);
                cont_kind  = K_STRING;
                cont_state = S_DQB;
            end
            S_SQB:
            begin
                cont       = 1'b1;
                cont_kind  = K_QCONST;
                cont_state = (in_ch_reg == CH_SQUOTE) ? S_SQC : S_SQB;
            end
            S_SQC:
            begin
                cont       = (in_ch_reg == CH_SQUOTE);
                cont_kind  = K_QCONST;
                cont_state = S_SQB;
            end
            S_SYM:
            begin
                cont      = !in_ch_reg[7] && (cls == C_SY);
                cont_kind = K_SYMBOL;
            end
            S_INT:
            begin
                cont      = !in_ch_reg[7] && (cls == C_DG);
                cont_kind = K_INT;
            end
            S_VAR:
            begin
                cont      = !in_ch_reg[7] && (cls == C_UP);
                cont_kind = K_VAR;
            end
            S_IDN:
            begin
                cont      = !in_ch_reg[7] && (cls == C_LO || cls == C_UP);
                cont_kind = K_IDENT;
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase
    end

    // Result and next state
    always_comb
    begin
        emit           = 1'b0;
        res_ch         = in_ch_reg;
        res_user       = '0;
        res_last       = 1'b0;
        lex_state_next = lex_state_reg;
        len_next       = len_reg;

        if (in_last_reg)
        begin
            // End of input: report an open token and return to idle
            emit                 = 1'b1;
            res_ch               = '0;
            res_last             = 1'b1;
            res_user.open_at_end = (lex_state_reg != S_IDLE);
            lex_state_next       = S_IDLE;
            len_next             = '0;
        end
        else if (cont)
        begin
            emit              = 1'b1;
            res_user.kind     = cont_kind;
            res_user.too_long = (len_inc > LEN_MAX);
            lex_state_next    = cont_state;
            len_next          = len_inc;
        end
        else if (in_ch_reg[7])
        begin
            // Illegal byte outside quotes closes any token
            emit              = 1'b1;
            res_user.bad_char = 1'b1;
            lex_state_next    = S_IDLE;
            len_next          = '0;
        end
        else
        begin
            // The word starts a fresh token, or is dropped as whitespace
            emit           = (cls != C_WS);
            res_user.first = 1'b1;
            len_next       = LEN_ONE;
            case (cls)
                C_WS:
                begin
                    lex_state_next = S_IDLE;
                    len_next       = '0;
                end
                C_DQ:
                begin
                    res_user.kind  = K_STRING;
                    lex_state_next = S_DQB;
                end
                C_SQ:
                begin
                    res_user.kind  = K_QCONST;
                    lex_state_next = S_SQB;
                end
                C_SO:
                begin
                    res_user.kind  = K_SOLO;
                    lex_state_next = S_IDLE;
                    len_next       = '0;
                end
                C_SY:
                begin
                    res_user.kind  = K_SYMBOL;
                    lex_state_next = S_SYM;
                end
                C_DG:
                begin
                    res_user.kind  = K_INT;
                    lex_state_next = S_INT;
                end
                C_UP:
                begin
                    res_user.kind  = K_VAR;
                    lex_state_next = S_VAR;
                end
                default:
                begin
                    res_user.kind  = K_IDENT;
                    lex_state_next = S_IDN;
                end
            endcase
            res_user.too_long = (LEN_ONE > LEN_MAX) && emit;
        end
    end

    // Lexer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_state_reg <= S_IDLE;
            len_reg       <= '0;
        end
        else if (advance)
        begin
            lex_state_reg <= lex_state_next;
            len_reg       <= len_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_ch_reg   <= res_ch;
            out_user_reg <= res_user;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ch_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // The end word carries no byte, no kind and no token flags
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |->
            out_ch_reg == '0 && out_user_reg.kind == K_STRING &&
            !out_user_reg.first && !out_user_reg.bad_char && !out_user_reg.too_long)
        else $error("end word carries token data");

    // An illegal byte never starts a token or counts as overlong
    a_bad_plain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg.bad_char |->
            !out_user_reg.first && !out_user_reg.too_long && !out_last_reg &&
            out_user_reg.kind == K_STRING)
        else $error("illegal byte result carries token flags");

    // End of input leaves the lexer idle with a zero count
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> lex_state_reg == S_IDLE && len_reg == '0)
        else $error("lexer not idle after end of input");

    // A first byte is never overlong, the limit being at least one
    a_first_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg.first |-> !out_user_reg.too_long)
        else $error("first byte flagged overlong");

endmodule

// ===== tb/sv/term_syntax_tokenizer_tb.sv =====
// Testbench for the term syntax tokenizer: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module term_syntax_tokenizer_tb;
    import tst_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 850;
    localparam int QUIET_TAIL     = 200;

    // One expected result word
    typedef struct packed {
        char_t ch;
        kind_t kind;
        logic  first;
        logic  at_end;
        logic  open_tok;
        logic  bad;
        logic  too_long;
    } token_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata = '0;   // [7:0] ch
    logic              s_tlast = 1'b0; // end_of_input
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;        // [7:0] char_out
    logic [USER_W-1:0] m_tuser;        // [2:0] kind, [3] first, [4] open_at_end,
                                       // [5] bad_char, [6] too_long
    logic              m_tlast;        // at_end

    // Predictor state and the store of words still to come
    lex_state_t  lx_state = S_IDLE;
    int          lx_len = 0;
    token_word_t tokens_due[$];
    int          words_sent = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    logic        idle_on = 1'b0;

    string solo_chars  = "!%(),;[]{|}";
    string sym_chars   = "#&*+-./:<=>?@\\^`~";
    string upper_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string lower_chars = "abcdefghijklmnopqrstuvwxyz$";
    string digit_chars = "0123456789";

    term_syntax_tokenizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Class of a 7-bit character; callers treat bytes of 128 and above apart.
    function automatic class_t ascii_class(input char_t c);
        class_t cls;
        cls = C_SY;
        case (c)
            "!", "%", "(", ")", ",", ";", "[", "]", "{", "|", "}": cls = C_SO;
            CH_DQUOTE: cls = C_DQ;
            CH_SQUOTE: cls = C_SQ;
            "$": cls = C_LO;
            "_": cls = C_UP;
            default:
            begin
                if (c <= 8'd32 || c == 8'd127)
                    cls = C_WS;
                else if (c >= "0" && c <= "9")
                    cls = C_DG;
                else if (c >= "A" && c <= "Z")
                    cls = C_UP;
                else if (c >= "a" && c <= "z")
                    cls = C_LO;
            end
        endcase
        return cls;
    endfunction

    function automatic void push_word(input token_word_t w);
        tokens_due.push_back(w);
    endfunction

    // A byte that joins or starts a token: count it and record the echo.
    function automatic void keep_byte(input char_t c, input kind_t k, input logic first,
                                      input lex_state_t nxt);
        token_word_t w;
        if (first)
            lx_len = 1;
        else if (lx_len <= TST_MAX_TOKEN_LEN)
            lx_len++;
        lx_state = nxt;
        w = '{c, k, first, 1'b0, 1'b0, 1'b0, lx_len > TST_MAX_TOKEN_LEN};
        push_word(w);
    endfunction

    // Next state and expected word for one accepted input word
    function automatic void lex_predict(input char_t c, input logic eoi);
        class_t cls;
        logic   legal;
        logic   taken;
        cls = ascii_class(c);
        legal = !c[7];
        taken = 1'b0;
        if (eoi)
        begin
            push_word('{8'd0, K_STRING, 1'b0, 1'b1, lx_state != S_IDLE, 1'b0, 1'b0});
            lx_state = S_IDLE;
            lx_len = 0;
            return;
        end
        // Continuation of an open token
        case (lx_state)
            S_DQB:
            begin
                keep_byte(c, K_STRING, 1'b0, (c == CH_DQUOTE) ? S_DQC : S_DQB);
                taken = 1'b1;
            end
            S_DQC:
            begin
                if (c == CH_DQUOTE)
                begin
                    keep_byte(c, K_STRING, 1'b0, S_DQB);
                    taken = 1'b1;
                end
            end
            S_SQB:
            begin
                keep_byte(c, K_QCONST, 1'b0, (c == CH_SQUOTE) ? S_SQC : S_SQB);
                taken = 1'b1;
            end
            S_SQC:
            begin
                if (c == CH_SQUOTE)
                begin
                    keep_byte(c, K_QCONST, 1'b0, S_SQB);
                    taken = 1'b1;
                end
            end
            S_SYM:
            begin
                if (legal && cls == C_SY)
                begin
                    keep_byte(c, K_SYMBOL, 1'b0, S_SYM);
                    taken = 1'b1;
                end
            end
            S_INT:
            begin
                if (legal && cls == C_DG)
                begin
                    keep_byte(c, K_INT, 1'b0, S_INT);
                    taken = 1'b1;
                end
            end
            S_VAR:
            begin
                if (legal && cls == C_UP)
                begin
                    keep_byte(c, K_VAR, 1'b0, S_VAR);
                    taken = 1'b1;
                end
            end
            S_IDN:
            begin
                if (legal && (cls == C_LO || cls == C_UP))
                begin
                    keep_byte(c, K_IDENT, 1'b0, S_IDN);
                    taken = 1'b1;
                end
            end
            default: ;
        endcase
        if (taken)
            return;
        // The open token closes and this byte is taken on its own
        lx_state = S_IDLE;
        lx_len = 0;
        if (!legal)
        begin
            push_word('{c, K_STRING, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
            return;
        end
        case (cls)
            C_DQ: keep_byte(c, K_STRING, 1'b1, S_DQB);
            C_SQ: keep_byte(c, K_QCONST, 1'b1, S_SQB);
            C_SO:
            begin
                keep_byte(c, K_SOLO, 1'b1, S_IDLE);
                lx_len = 0;
            end
            C_SY: keep_byte(c, K_SYMBOL, 1'b1, S_SYM);
            C_DG: keep_byte(c, K_INT, 1'b1, S_INT);
            C_UP: keep_byte(c, K_VAR, 1'b1, S_VAR);
            C_LO: keep_byte(c, K_IDENT, 1'b1, S_IDN);
            default: ;
        endcase
    endfunction

    // Send one word, with a random gap ahead of it while idling is on.
    task automatic send_word(input char_t c, input logic eoi);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        lex_predict(c, eoi);
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_word(txt[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_word(char_t'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic char_t pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Hold the sender until every expected word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        token_word_t exp_w;
        res_user_t   flags;
        if (rst_n && m_tvalid && m_tready)
        begin
            flags = res_user_t'(m_tuser);
            if (tokens_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual data %0d user %0d last %0d",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                exp_w = tokens_due.pop_front();
                check_field("char_out", exp_w.ch, m_tdata);
                check_field("kind", exp_w.kind, flags.kind);
                check_field("first", exp_w.first, flags.first);
                check_field("at_end", exp_w.at_end, m_tlast);
                check_field("open_at_end", exp_w.open_tok, flags.open_at_end);
                check_field("bad_char", exp_w.bad, flags.bad_char);
                check_field("too_long", exp_w.too_long, flags.too_long);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("term_syntax_tokenizer_tb NOT OK");
                $finish;
            end
        end
    end

    // Each token kind, doubled quotes, bytes above 127 inside and outside quotes,
    // and end of input in the idle, open and just-closed states.
    task automatic test_directed();
        send_word(8'h00, 1'b0);
        send_text("foO99Va;+-\"");
        send_word(8'hFF, 1'b0);
        send_text("\"\"x\"");
        send_eoi();
        send_text("'''q' ");
        send_word(8'h80, 1'b0);
        send_text("$A_7");
        send_word(8'hFF, 1'b0);
        send_eoi();
        send_text("42");
        send_eoi();
    endtask

    // Tokens longer than the limit, including the saturating count.
    task automatic test_overlong();
        int    i;
        char_t b;
        for (i = 0; i < TST_MAX_TOKEN_LEN + 44; i++)
            send_word(pick_char(lower_chars), 1'b0);
        send_eoi();
        send_word(CH_SQUOTE, 1'b0);
        for (i = 0; i < TST_MAX_TOKEN_LEN + 4; i++)
        begin
            // Any byte but the quote keeps the constant open
            b = char_t'($urandom_range(0, 255));
            if (b == CH_SQUOTE)
                b = 8'h41;
            send_word(b, 1'b0);
        end
        send_word(CH_SQUOTE, 1'b0);
        send_word(" ", 1'b0);
    endtask

    // One random token, mostly well formed, sometimes noise or left open.
    task automatic send_token();
        int    pick;
        int    len;
        int    i;
        char_t q;
        pick = $urandom_range(0, 19);
        len  = $urandom_range(1, 8);
        if (pick < 4)
        begin
            q = (pick < 2) ? CH_DQUOTE : CH_SQUOTE;
            send_word(q, 1'b0);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_word(q, 1'b0);
                    send_word(q, 1'b0);
                end
                else
                begin
                    send_word(char_t'($urandom_range(0, 255)), 1'b0);
                end
            end
            if ($urandom_range(0, 9) != 0)
                send_word(q, 1'b0);
            else if ($urandom_range(0, 1) == 0)
                send_eoi();
        end
        else if (pick < 6)
        begin
            send_word(pick_char(solo_chars), 1'b0);
        end
        else if (pick < 8)
        begin
            for (i = 0; i < len; i++)
                send_word(pick_char(sym_chars), 1'b0);
        end
        else if (pick < 10)
        begin
            for (i = 0; i < len; i++)
                send_word(pick_char(digit_chars), 1'b0);
        end
        else if (pick < 12)
        begin
            for (i = 0; i < len; i++)
                send_word(pick_char(upper_chars), 1'b0);
        end
        else if (pick < 14)
        begin
            send_word(pick_char(lower_chars), 1'b0);
            for (i = 1; i < len; i++)
                send_word($urandom_range(0, 1) ? pick_char(lower_chars)
                                              : pick_char(upper_chars), 1'b0);
        end
        else if (pick < 16)
        begin
            send_word($urandom_range(0, 7) == 0 ? 8'd127 : char_t'($urandom_range(0, 32)),
                      1'b0);
        end
        else if (pick < 18)
        begin
            send_word(char_t'($urandom_range(0, 255)), 1'b0);
        end
        else if (pick == 18)
        begin
            send_eoi();
        end
        else
        begin
            send_word(char_t'($urandom_range(128, 255)), 1'b0);
        end
        if ($urandom_range(0, 1) == 0)
            send_word(" ", 1'b0);
    endtask

    // Random token streams with idle phases, quiet stretches and one full drain.
    task automatic test_random_text();
        int start;
        int done;
        logic drained;
        start = words_sent;
        drained = 1'b0;
        done = 0;
        while (done < RANDOM_WORDS)
        begin
            if (done >= RANDOM_WORDS - QUIET_TAIL)
                idle_on <= 1'b0;
            else
                idle_on <= ((done / 150) % 3) != 2;
            if (!drained && done >= RANDOM_WORDS / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
            send_token();
            done = words_sent - start;
        end
        send_eoi();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;
        test_directed();
        wait_drained();
        test_overlong();
        wait_drained();
        test_random_text();
        wait_drained();
        repeat (8) @(posedge clk);
        if (tokens_due.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived, expected 0, actual %0d",
                     $time, tokens_due.size(), tokens_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("term_syntax_tokenizer_tb OK");
        else
            $display("term_syntax_tokenizer_tb NOT OK");
        $finish;
    end

endmodule
